// ===== hdl/sector_proximity_alarm_assert.svh =====
// Assertion macros used by the checker of the proximity alarm block.
// Both forms sample on i_clk and are switched off while i_rst_n is low.
`ifndef SECTOR_PROXIMITY_ALARM_ASSERT_SVH
`define SECTOR_PROXIMITY_ALARM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spa_pkg.sv =====
`timescale 1ns / 1ps

package spa_pkg;

    localparam int ANGLE_COUNT  = 360;
    localparam int SECTOR_COUNT = 9;

    localparam int MID_INDEX       = SECTOR_COUNT / 2;
    localparam int NO_READING_CEIL = 20000;
    localparam int EMPTY_SECTOR    = 9999;
    localparam int SECTOR_BASE     = 45;
    localparam int SECTOR_STEP     = 30;
    localparam int SECTOR_SPAN     = 30;
    localparam int MID_START       = 170;
    localparam int MID_SPAN        = 20;

    localparam int ADDR_W = $clog2(ANGLE_COUNT);
    localparam int SECT_W = $clog2(SECTOR_COUNT);
    localparam int SPAN_W = $clog2((SECTOR_SPAN > MID_SPAN) ? SECTOR_SPAN : MID_SPAN);

    localparam int MAP_W       = 16;
    localparam int DIST_W      = 15;
    localparam int SPEED_W     = 10;
    localparam int LEVEL_W     = 2;
    localparam int TURN_W      = 2;
    localparam int SECT_OUT_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int ANGLE_IN_W  = 9;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED = 2'd2;

    localparam logic [DIST_W-1:0]  ALARM_THR_RST  = 15'd200;
    localparam logic [DIST_W-1:0]  WAKE_THR_RST   = 15'd420;
    localparam logic [SPEED_W-1:0] SPIN_SPEED_RST = 10'd450;

    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WAKE   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ALARM  = 2'd2;

    localparam logic [TURN_W-1:0] TURN_STOP  = 2'd0;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SECT_W-1:0] t_sect;
    typedef logic [SPAN_W-1:0] t_span;
    typedef logic [MAP_W-1:0]  t_map;
    typedef logic [DIST_W-1:0] t_dist;

    typedef logic [SECTOR_COUNT-1:0][ADDR_W-1:0] t_start_tbl;

    typedef struct packed {
        t_dist              alarm_thr;
        t_dist              wake_thr;
        logic [SPEED_W-1:0] spin_speed;
    } t_scan_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0]    level;
        logic [TURN_W-1:0]     turn;
        logic [SPEED_W-1:0]    speed;
        logic [SECT_OUT_W-1:0] sector;
        t_dist                 near_dist;
    } t_scan_res;

    // First map address of every sector, wrapped onto the map.
    function automatic t_start_tbl calc_starts();
        t_start_tbl tbl;
        int         s;
        for (int i = 0; i < SECTOR_COUNT; i++) begin
            if (i == MID_INDEX) begin
                s = MID_START % ANGLE_COUNT;
            end else begin
                s = (SECTOR_BASE + SECTOR_STEP * i) % ANGLE_COUNT;
            end
            tbl[i] = ADDR_W'(s);
        end
        return tbl;
    endfunction

    localparam t_start_tbl SECTOR_STARTS = calc_starts();

endpackage

// ===== hdl/spa_map.sv =====
`timescale 1ns / 1ps

module spa_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  spa_pkg::t_addr i_wr_addr,
    input  spa_pkg::t_map  i_wr_data,
    input  spa_pkg::t_addr i_rd_addr,
    output spa_pkg::t_map  o_rd_data,
    output logic          o_ready
);

    spa_pkg::t_map  r_mem [spa_pkg::ANGLE_COUNT];
    spa_pkg::t_map  r_rd_data;
    spa_pkg::t_addr r_clr_addr;
    logic           r_clearing;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == spa_pkg::ADDR_W'(spa_pkg::ANGLE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

// ===== hdl/spa_scan.sv =====
`timescale 1ns / 1ps

module spa_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  spa_pkg::t_scan_cfg i_cfg,
    input  logic               i_out_free,
    output logic               o_idle,
    output spa_pkg::t_addr     o_rd_addr,
    input  spa_pkg::t_map      i_rd_data,
    output logic               o_res_valid,
    output spa_pkg::t_scan_res o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_SECT,
        S_LVL_ALARM,
        S_LVL_WAKE,
        S_DONE
    } t_state;

    t_state                          r_state;
    spa_pkg::t_sect                  r_sect;
    spa_pkg::t_span                  r_k;
    spa_pkg::t_addr                  r_addr;
    spa_pkg::t_dist                  r_sec_min;
    spa_pkg::t_dist                  r_best;
    spa_pkg::t_sect                  r_best_idx;
    logic [spa_pkg::LEVEL_W-1:0]     r_level;

    spa_pkg::t_addr addr_inc;
    spa_pkg::t_span last_k;
    spa_pkg::t_map  op_a;
    spa_pkg::t_map  op_b;
    logic           lt;
    logic           last_sect;

    assign addr_inc = (r_addr == spa_pkg::ADDR_W'(spa_pkg::ANGLE_COUNT - 1)) ?
                      '0 : r_addr + 1'b1;
    assign last_k = (r_sect == spa_pkg::SECT_W'(spa_pkg::MID_INDEX)) ?
                    spa_pkg::SPAN_W'(spa_pkg::MID_SPAN - 1) :
                    spa_pkg::SPAN_W'(spa_pkg::SECTOR_SPAN - 1);
    assign last_sect = (r_sect == spa_pkg::SECT_W'(spa_pkg::SECTOR_COUNT - 1));

    // The one comparator of the block; each state picks its operands.
    always_comb begin
        op_a      = '0;
        op_b      = '0;
        o_rd_addr = r_addr;
        unique case (r_state)
            S_ADDR: begin
                o_rd_addr = spa_pkg::SECTOR_STARTS[r_sect];
            end
            S_CMP: begin
                op_a      = i_rd_data;
                op_b      = {1'b0, r_sec_min};
                o_rd_addr = addr_inc;
            end
            S_SECT: begin
                op_a = {1'b0, r_sec_min};
                op_b = {1'b0, r_best};
            end
            S_LVL_ALARM: begin
                op_a = {1'b0, i_cfg.alarm_thr};
                op_b = {1'b0, r_best};
            end
            S_LVL_WAKE: begin
                op_a = {1'b0, i_cfg.wake_thr};
                op_b = {1'b0, r_best};
            end
            default: begin
            end
        endcase
        lt = (op_a < op_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sect     <= '0;
                        r_best     <= spa_pkg::DIST_W'(spa_pkg::EMPTY_SECTOR);
                        r_best_idx <= spa_pkg::SECT_W'(spa_pkg::MID_INDEX);
                        r_state    <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr    <= spa_pkg::SECTOR_STARTS[r_sect];
                    r_k       <= '0;
                    r_sec_min <= spa_pkg::DIST_W'(spa_pkg::NO_READING_CEIL);
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    if ((i_rd_data != '0) && lt) begin
                        r_sec_min <= i_rd_data[spa_pkg::DIST_W-1:0];
                    end
                    if (r_k == last_k) begin
                        r_state <= S_SECT;
                    end else begin
                        r_k    <= r_k + 1'b1;
                        r_addr <= addr_inc;
                    end
                end
                S_SECT: begin
                    // An empty sector keeps its minimum at the ceiling, which
                    // never beats the running best.
                    if (lt) begin
                        r_best     <= r_sec_min;
                        r_best_idx <= r_sect;
                    end
                    if (last_sect) begin
                        r_state <= S_LVL_ALARM;
                    end else begin
                        r_sect  <= r_sect + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                S_LVL_ALARM: begin
                    if (!lt) begin
                        r_level <= spa_pkg::LEVEL_ALARM;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LVL_WAKE;
                    end
                end
                S_LVL_WAKE: begin
                    r_level <= lt ? spa_pkg::LEVEL_NORMAL : spa_pkg::LEVEL_WAKE;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_res.level     = r_level;
        o_res.sector    = spa_pkg::SECT_OUT_W'(r_best_idx);
        o_res.near_dist = r_best;
        if (r_best_idx < spa_pkg::SECT_W'(spa_pkg::MID_INDEX)) begin
            o_res.turn  = spa_pkg::TURN_LEFT;
            o_res.speed = i_cfg.spin_speed;
        end else if (r_best_idx > spa_pkg::SECT_W'(spa_pkg::MID_INDEX)) begin
            o_res.turn  = spa_pkg::TURN_RIGHT;
            o_res.speed = i_cfg.spin_speed;
        end else begin
            o_res.turn  = spa_pkg::TURN_STOP;
            o_res.speed = '0;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

endmodule

// ===== hdl/sector_proximity_alarm.sv =====
`timescale 1ns / 1ps
// Proximity alarm over a 360-degree lidar map.
// Input channel (i_in_valid / o_in_ready): one beat is a mode, an angle and a
// distance. A mode-0 beat stores the distance for that angle and
// gives no result; angles past the map are dropped. A mode-1 beat evaluates
// the nine sectors and gives exactly one result beat.
// An evaluation walks the sector entries through one comparator, one entry per
// cycle, with a state to start (S_ADDR) and one to close (S_SECT) each sector;
// then S_LVL_ALARM and, unless the alarm is raised, S_LVL_WAKE set the level,
// and S_DONE hands the result over. The input is not ready meanwhile.
// Output channel (o_out_valid / i_out_ready): a result sits in an output
// register until taken. Store beats are still accepted while it waits; a new
// evaluation holds its result until the register is free.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; index 0
// is the alarm threshold, 1 the wake threshold, 2 the spin speed. Write it
// only while the block is idle.
// Reset (i_rst_n low, synchronous) restores the register defaults and then
// zeroes the map, one entry a cycle: o_in_ready stays low until it is cleared.
module sector_proximity_alarm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [spa_pkg::ANGLE_IN_W-1:0]      i_angle,
    input  logic [spa_pkg::MAP_W-1:0]           i_distance,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [spa_pkg::LEVEL_W-1:0]         o_alarm_level,
    output logic [spa_pkg::TURN_W-1:0]          o_turn,
    output logic [spa_pkg::SPEED_W-1:0]         o_motor_speed,
    output logic [spa_pkg::SECT_OUT_W-1:0]      o_nearest_sector,
    output logic [spa_pkg::DIST_W-1:0]          o_nearest_distance,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [spa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    spa_pkg::t_scan_cfg r_cfg;
    spa_pkg::t_scan_res r_out;
    logic               r_out_valid;

    spa_pkg::t_scan_res scan_res;
    spa_pkg::t_addr     rd_addr;
    spa_pkg::t_map      rd_data;
    logic               map_ready;
    logic               scan_idle;
    logic               scan_done;
    logic               out_free;
    logic               in_accept;
    logic               in_range;
    logic               wr_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_thr  <= spa_pkg::ALARM_THR_RST;
            r_cfg.wake_thr   <= spa_pkg::WAKE_THR_RST;
            r_cfg.spin_speed <= spa_pkg::SPIN_SPEED_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spa_pkg::CFG_ALARM_THR:  r_cfg.alarm_thr  <= i_cfg_data;
                spa_pkg::CFG_WAKE_THR:   r_cfg.wake_thr   <= i_cfg_data;
                spa_pkg::CFG_SPIN_SPEED: r_cfg.spin_speed <= i_cfg_data[spa_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = map_ready && scan_idle;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_angle) < spa_pkg::ANGLE_COUNT);
    assign wr_en      = in_accept && !i_mode && in_range;

    spa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (spa_pkg::ADDR_W'(i_angle)),
        .i_wr_data (i_distance),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_ready   (map_ready)
    );

    assign out_free = !r_out_valid || i_out_ready;

    spa_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept && i_mode),
        .i_cfg       (r_cfg),
        .i_out_free  (out_free),
        .o_idle      (scan_idle),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (scan_done),
        .o_res       (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && scan_done) begin
            r_out <= scan_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_alarm_level      = r_out.level;
    assign o_turn             = r_out.turn;
    assign o_motor_speed      = r_out.speed;
    assign o_nearest_sector   = r_out.sector;
    assign o_nearest_distance = r_out.near_dist;

endmodule

// ===== hdl/spa_checker.sv =====
`timescale 1ns / 1ps
`include "sector_proximity_alarm_assert.svh"

module spa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_mode,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [spa_pkg::LEVEL_W-1:0]         o_alarm_level,
    input logic [spa_pkg::TURN_W-1:0]          o_turn,
    input logic [spa_pkg::SPEED_W-1:0]         o_motor_speed,
    input logic [spa_pkg::SECT_OUT_W-1:0]      o_nearest_sector,
    input logic [spa_pkg::DIST_W-1:0]          o_nearest_distance
);

    // A stalled result beat keeps its payload.
    `SPA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_nearest_distance) && $stable(o_nearest_sector) && $stable(o_alarm_level), "result changed while stalled")

    // An evaluation beat makes the block busy in the next cycle.
    `SPA_ASSERT_NEXT(a_eval_busy, i_in_valid && o_in_ready && i_mode, !o_in_ready, "input ready right after an evaluation beat")

    // Stopping means the middle sector won, at zero speed.
    `SPA_ASSERT_NOW(a_stop_mid, o_out_valid && (o_turn == spa_pkg::TURN_STOP), (o_motor_speed == '0) && (o_nearest_sector == spa_pkg::SECT_OUT_W'(spa_pkg::MID_INDEX)), "stop without middle sector")

    // An empty result names the middle sector; a found one is a real reading.
    `SPA_ASSERT_NOW(a_dist_range, o_out_valid, (o_nearest_distance != '0) && (o_nearest_distance <= spa_pkg::DIST_W'(spa_pkg::EMPTY_SECTOR)) && ((o_nearest_distance != spa_pkg::DIST_W'(spa_pkg::EMPTY_SECTOR)) || (o_nearest_sector == spa_pkg::SECT_OUT_W'(spa_pkg::MID_INDEX))), "nearest distance out of range")

endmodule

bind sector_proximity_alarm spa_checker u_spa_checker (.*);
